// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deadline queue checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ETDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("etdq check failed");

// Check cons in the cycle after ante.
`define ETDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etdq check failed");

`endif

// ===== rtl/etdq_pkg.sv =====
// ---------------------------------------------------------------------------
// etdq_pkg
// Types, sizes and codes shared by the deadline queue modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package etdq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 64;
    localparam int TAG_W       = 8;
    localparam int DELAY_W     = 32;
    localparam int FUNC_W      = 2;
    localparam int KIND_W      = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK    = 2'd0,
        FN_REQUEST = 2'd1,
        FN_CANCEL  = 2'd2,
        FN_READ    = 2'd3
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        K_ACCEPTED  = 3'd0,
        K_EXPIRED   = 3'd1,
        K_TIMEDOUT  = 3'd2,
        K_CANCELLED = 3'd3,
        K_BUSY      = 3'd4,
        K_FULL      = 3'd5,
        K_TIME      = 3'd6
    } kind_t;

    typedef struct packed {
        logic  accept;
        logic  tick_inc;
        logic  scan_clear;
        logic  scan_step;
        logic  find_step;
        logic  calc;
        logic  emit;
        kind_t kind;
        logic  last;
        logic  wr_entry;
        logic  clr_best;
        logic  clr_idx;
    } etdq_cmd_t;

    typedef struct packed {
        logic out_free;
        logic running;
        logic scan_done;
        logic elig_any;
        logic exp_last;
        logic dl_late;
        logic q_full;
        logic tag_hit;
    } etdq_status_t;

endpackage

`default_nettype wire

// ===== rtl/etdq_if.sv =====
// ---------------------------------------------------------------------------
// etdq channel interfaces
// Item, result and configuration channels with valid/ready transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface etdq_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  request_tag;
    logic [31:0] delay;
    logic [63:0] deadline;

    modport source (output valid, func, request_tag, delay, deadline, input ready);
    modport sink   (input valid, func, request_tag, delay, deadline, output ready);
endinterface

interface etdq_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [7:0]  result_tag;
    logic [63:0] time_value;
    logic        last_result;

    modport source (output valid, result_kind, result_tag, time_value, last_result,
                    input ready);
    modport sink   (input valid, result_kind, result_tag, time_value, last_result,
                    output ready);
endinterface

interface etdq_cfg_if;
    logic valid;
    logic ready;
    logic hold_running;

    modport source (output valid, hold_running, input ready);
    modport sink   (input valid, hold_running, output ready);
endinterface

`default_nettype wire

// ===== rtl/etdq_ctrl.sv =====
// ---------------------------------------------------------------------------
// etdq_ctrl
// Sequencer for tick scans, request placement, cancel search and reads.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module etdq_ctrl
    import etdq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_valid,
    input  wire logic [1:0]   item_func,
    output logic              item_ready,
    input  wire etdq_status_t status,
    output etdq_cmd_t         cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_EXPIRE = 7'b0000100,
        S_CALC   = 7'b0001000,
        S_PLACE  = 7'b0010000,
        S_FIND   = 7'b0100000,
        S_READ   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    func_t  func_in;

    assign func_in = func_t'(item_func);

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        cmd.kind   = K_ACCEPTED;
        case (state_reg)
            S_IDLE:
            begin
                item_ready     = 1'b1;
                cmd.scan_clear = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    case (func_in)
                        FN_TICK:
                        begin
                            cmd.tick_inc = status.running;
                            state_next   = S_SCAN;
                        end
                        FN_REQUEST: state_next = S_CALC;
                        FN_CANCEL:  state_next = S_FIND;
                        default:    state_next = S_READ;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                    state_next = S_EXPIRE;
            end
            S_EXPIRE:
            begin
                if (!status.elig_any)
                    state_next = S_IDLE;
                else if (status.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.kind       = K_EXPIRED;
                    cmd.last       = status.exp_last;
                    cmd.clr_best   = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = status.exp_last ? S_IDLE : S_SCAN;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    if (status.dl_late)
                        cmd.kind = K_TIMEDOUT;
                    else if (status.q_full)
                        cmd.kind = K_FULL;
                    else
                    begin
                        cmd.kind     = K_ACCEPTED;
                        cmd.wr_entry = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FIND:
            begin
                if (status.tag_hit)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.last    = 1'b1;
                        cmd.kind    = K_CANCELLED;
                        cmd.clr_idx = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (status.scan_done)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.last   = 1'b1;
                        cmd.kind   = K_TIMEDOUT;
                        state_next = S_IDLE;
                    end
                end
                else
                    cmd.find_step = 1'b1;
            end
            S_READ:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.kind   = status.running ? K_TIME : K_BUSY;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== rtl/etdq_dp.sv =====
// ---------------------------------------------------------------------------
// etdq_dp
// Time counter, deadline slots, entry scan and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module etdq_dp
    import etdq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire etdq_cmd_t          cmd,
    output etdq_status_t            status,
    input  wire logic [TAG_W-1:0]   item_tag,
    input  wire logic [DELAY_W-1:0] item_delay,
    input  wire logic [TIME_W-1:0]  item_deadline,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_hold,
    output logic                    res_valid,
    output logic [KIND_W-1:0]       res_kind,
    output logic [TAG_W-1:0]        res_tag,
    output logic [TIME_W-1:0]       res_time,
    output logic                    res_last,
    input  wire logic               res_ready
);

    logic [TIME_W-1:0]      dl_mem [QUEUE_DEPTH];
    logic [TAG_W-1:0]       tag_mem [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic                   hold_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic [DELAY_W-1:0]     delay_reg;
    logic [TIME_W-1:0]      deadline_reg;
    logic [TIME_W-1:0]      cand_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   found_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [TIME_W-1:0]      best_dl_reg;
    logic [TAG_W-1:0]       best_tag_reg;
    logic [CNT_W-1:0]       elig_reg;
    logic [EMIT_W-1:0]      emit_reg;
    logic                   out_valid_reg;
    kind_t                  out_kind_reg;
    logic [TAG_W-1:0]       out_tag_reg;
    logic [TIME_W-1:0]      out_time_reg;
    logic                   out_last_reg;

    logic [TIME_W-1:0]      entry_dl;
    logic [TAG_W-1:0]       entry_tag;
    logic                   entry_elig;
    logic                   entry_better;
    logic [IDX_W-1:0]       free_slot;
    logic [TIME_W-1:0]      cand_next;
    logic [TAG_W-1:0]       out_tag_next;

    assign entry_dl     = dl_mem[idx_reg];
    assign entry_tag    = tag_mem[idx_reg];
    assign entry_elig   = valid_reg[idx_reg] && (entry_dl <= now_reg);
    assign entry_better = entry_elig && (!found_reg || (entry_dl < best_dl_reg));

    always_comb
    begin
        free_slot = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_slot = IDX_W'(i);
        end
    end

    assign cand_next = (delay_reg != '0) ? (now_reg + TIME_W'(delay_reg)) : deadline_reg;

    always_comb
    begin
        case (cmd.kind)
            K_EXPIRED:      out_tag_next = best_tag_reg;
            K_TIME, K_BUSY: out_tag_next = '0;
            default:        out_tag_next = tag_reg;
        endcase
    end

    assign status.out_free  = !out_valid_reg || res_ready;
    assign status.running   = (|valid_reg) || hold_reg;
    assign status.scan_done = (idx_reg == IDX_W'(QUEUE_DEPTH - 1));
    assign status.elig_any  = (elig_reg != '0);
    assign status.exp_last  = (elig_reg == CNT_W'(1)) || (emit_reg == EMIT_W'(MAX_RESULTS - 1));
    assign status.dl_late   = (cand_reg <= now_reg);
    assign status.q_full    = &valid_reg;
    assign status.tag_hit   = valid_reg[idx_reg] && (entry_tag == tag_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_entry)
        begin
            dl_mem[free_slot]  <= cand_reg;
            tag_mem[free_slot] <= tag_reg;
        end
        if (cmd.accept)
        begin
            tag_reg      <= item_tag;
            delay_reg    <= item_delay;
            deadline_reg <= item_deadline;
        end
        if (cmd.calc)
            cand_reg <= cand_next;
        if (cmd.scan_step && entry_better)
        begin
            best_idx_reg <= idx_reg;
            best_dl_reg  <= entry_dl;
            best_tag_reg <= entry_tag;
        end
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.kind;
            out_tag_reg  <= out_tag_next;
            out_time_reg <= (cmd.kind == K_BUSY) ? '0 : now_reg;
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            hold_reg      <= 1'b0;
            now_reg       <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            elig_reg      <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                hold_reg <= cfg_hold;
            if (cmd.tick_inc)
                now_reg <= now_reg + TIME_W'(1);
            if (cmd.wr_entry)
                valid_reg[free_slot] <= 1'b1;
            if (cmd.clr_best)
                valid_reg[best_idx_reg] <= 1'b0;
            if (cmd.clr_idx)
                valid_reg[idx_reg] <= 1'b0;
            if (cmd.accept)
                emit_reg <= '0;
            else if (cmd.emit && (cmd.kind == K_EXPIRED))
                emit_reg <= emit_reg + EMIT_W'(1);
            if (cmd.scan_clear)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                elig_reg  <= '0;
            end
            else if (cmd.scan_step)
            begin
                if (!status.scan_done)
                    idx_reg <= idx_reg + IDX_W'(1);
                if (entry_better)
                    found_reg <= 1'b1;
                if (entry_elig)
                    elig_reg <= elig_reg + CNT_W'(1);
            end
            else if (cmd.find_step)
                idx_reg <= idx_reg + IDX_W'(1);
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_kind  = out_kind_reg;
    assign res_tag   = out_tag_reg;
    assign res_time  = out_time_reg;
    assign res_last  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/extended_timer_deadline_queue_core.sv =====
// A read passes through S_READ, a request through S_CALC and S_PLACE, and a
// cancel steps through the slots in S_FIND. A tick scans all slots in S_SCAN
// one entry per cycle, once per expiration (up to 8) or once if none is due.
// One item at a time; a new item is taken while the last result waits in
// the output register. Reset: time zero, queue empty, timer stopped, hold off.
// ---------------------------------------------------------------------------
// extended_timer_deadline_queue_core
// 64-bit extended timer with a bounded queue of pending deadlines.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module extended_timer_deadline_queue_core
    import etdq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    etdq_item_if.sink     item,
    etdq_result_if.source result,
    etdq_cfg_if.sink      cfg
);

    etdq_cmd_t    cmd;
    etdq_status_t status;

    assign cfg.ready = 1'b1;

    etdq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_func  (item.func),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    etdq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .item_tag      (item.request_tag),
        .item_delay    (item.delay),
        .item_deadline (item.deadline),
        .cfg_valid     (cfg.valid),
        .cfg_hold      (cfg.hold_running),
        .res_valid     (result.valid),
        .res_kind      (result.result_kind),
        .res_tag       (result.result_tag),
        .res_time      (result.time_value),
        .res_last      (result.last_result),
        .res_ready     (result.ready)
    );

endmodule

`default_nettype wire

// ===== rtl/etdq_checker.sv =====
// ---------------------------------------------------------------------------
// etdq_checker
// Port-level checks on the result channel of the deadline queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module etdq_checker
    import etdq_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire logic [KIND_W-1:0] result_kind,
    input wire logic [TAG_W-1:0]  result_tag,
    input wire logic [TIME_W-1:0] time_value,
    input wire logic              last_result
);

    logic stall;
    logic is_busy;
    logic is_time;

    assign stall   = result_valid && !result_ready;
    assign is_busy = (result_kind == K_BUSY);
    assign is_time = (result_kind == K_TIME);

    `ETDQ_ASSERT_NEXT(a_result_hold, clk, rst_n, stall, result_valid && $stable(result_kind) && $stable(time_value))
    `ETDQ_ASSERT_NOW(a_busy_zero, clk, rst_n, result_valid && is_busy, time_value == '0 && result_tag == '0)
    `ETDQ_ASSERT_NOW(a_time_untagged, clk, rst_n, result_valid && is_time, result_tag == '0)
    `ETDQ_ASSERT_NOW(a_single_last, clk, rst_n, result_valid && result_kind != K_EXPIRED, last_result)

endmodule

bind extended_timer_deadline_queue_core etdq_checker u_etdq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_kind  (result.result_kind),
    .result_tag   (result.result_tag),
    .time_value   (result.time_value),
    .last_result  (result.last_result)
);

`default_nettype wire

// ===== tb/etdq_checker.sv =====
// ---------------------------------------------------------------------------
// etdq_scoreboard
// Watches the item, result and configuration channels of the deadline queue,
// keeps its own timer and slot state, and compares every result transfer
// field by field against the oldest predicted outcome.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module etdq_scoreboard
    import etdq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    etdq_item_if      item,
    etdq_result_if    result,
    etdq_cfg_if       cfg,
    output int        errors,
    output int        outstanding,
    output int        checked
);

    typedef struct packed {
        kind_t              kind;
        logic [TAG_W-1:0]   tag;
        logic [TIME_W-1:0]  tv;
        logic               last;
    } outcome_t;

    outcome_t           outcome_q[$];
    logic [TIME_W-1:0]  now_t;
    logic               run_t;
    logic               hold_t;
    logic [TIME_W-1:0]  slot_dl  [QUEUE_DEPTH];
    logic [TAG_W-1:0]   slot_tag [QUEUE_DEPTH];
    logic               slot_vld [QUEUE_DEPTH];

    function automatic outcome_t make_outcome(kind_t k, logic [TAG_W-1:0] t,
                                              logic [TIME_W-1:0] v, logic l);
        outcome_t o;
        o.kind = k;
        o.tag  = t;
        o.tv   = v;
        o.last = l;
        return o;
    endfunction

    task automatic refresh_running();
        logic any;
        any = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            any = any | slot_vld[i];
        run_t = any | hold_t;
    endtask

    task automatic predict_item(func_t fn, logic [TAG_W-1:0] tag,
                                logic [DELAY_W-1:0] dly, logic [TIME_W-1:0] dl);
        int                emitted;
        int                best;
        int                slot;
        logic              done;
        logic [TIME_W-1:0] target;
        emitted = 0;
        done    = 1'b0;
        slot    = -1;
        case (fn)
            FN_TICK: begin
                if (run_t)
                    now_t = now_t + 64'd1;
                while (!done && emitted < MAX_RESULTS) begin
                    best = -1;
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                        if (slot_vld[i] && slot_dl[i] <= now_t &&
                            (best < 0 || slot_dl[i] < slot_dl[best]))
                            best = i;
                    if (best < 0)
                        done = 1'b1;
                    else begin
                        slot_vld[best] = 1'b0;
                        outcome_q.push_back(make_outcome(K_EXPIRED, slot_tag[best],
                                                         now_t, 1'b0));
                        emitted++;
                    end
                end
                if (emitted > 0)
                    outcome_q[outcome_q.size() - 1].last = 1'b1;
            end
            FN_REQUEST: begin
                target = (dly != '0) ? now_t + {32'd0, dly} : dl;
                if (target <= now_t)
                    outcome_q.push_back(make_outcome(K_TIMEDOUT, tag, now_t, 1'b1));
                else begin
                    for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
                        if (!slot_vld[i])
                            slot = i;
                    if (slot < 0)
                        outcome_q.push_back(make_outcome(K_FULL, tag, now_t, 1'b1));
                    else begin
                        slot_vld[slot] = 1'b1;
                        slot_dl[slot]  = target;
                        slot_tag[slot] = tag;
                        outcome_q.push_back(make_outcome(K_ACCEPTED, tag, now_t, 1'b1));
                    end
                end
            end
            FN_CANCEL: begin
                for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
                    if (slot_vld[i] && slot_tag[i] == tag)
                        slot = i;
                if (slot < 0)
                    outcome_q.push_back(make_outcome(K_TIMEDOUT, tag, now_t, 1'b1));
                else begin
                    slot_vld[slot] = 1'b0;
                    outcome_q.push_back(make_outcome(K_CANCELLED, tag, now_t, 1'b1));
                end
            end
            default: begin
                if (run_t)
                    outcome_q.push_back(make_outcome(K_TIME, '0, now_t, 1'b1));
                else
                    outcome_q.push_back(make_outcome(K_BUSY, '0, '0, 1'b1));
            end
        endcase
        refresh_running();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        outcome_t exp_r;
        if (!rst_n)
        begin
            outcome_q.delete();
            now_t       = '0;
            run_t       = 1'b0;
            hold_t      = 1'b0;
            errors      = 0;
            outstanding = 0;
            checked     = 0;
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                slot_vld[i] = 1'b0;
                slot_dl[i]  = '0;
                slot_tag[i] = '0;
            end
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                hold_t = cfg.hold_running;
                refresh_running();
            end
            if (result.valid && result.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    $error("result_kind: expected none, actual %0d", result.result_kind);
                end
                else
                begin
                    exp_r = outcome_q.pop_front();
                    checked++;
                    if (result.result_kind !== exp_r.kind)
                    begin
                        errors++;
                        $error("result_kind: expected %0d, actual %0d",
                               exp_r.kind, result.result_kind);
                    end
                    if (result.result_tag !== exp_r.tag)
                    begin
                        errors++;
                        $error("result_tag: expected %0d, actual %0d",
                               exp_r.tag, result.result_tag);
                    end
                    if (result.time_value !== exp_r.tv)
                    begin
                        errors++;
                        $error("time_value: expected %0d, actual %0d",
                               exp_r.tv, result.time_value);
                    end
                    if (result.last_result !== exp_r.last)
                    begin
                        errors++;
                        $error("last_result: expected %0d, actual %0d",
                               exp_r.last, result.last_result);
                    end
                end
            end
            if (item.valid && item.ready)
                predict_item(func_t'(item.func), item.request_tag, item.delay,
                             item.deadline);
            outstanding = outcome_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Drives the deadline queue with a directed opening and random phases under
// random gaps and output stalls, switching the hold setting between phases;
// the checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import etdq_pkg::*;

    localparam int LIMIT_CYCLES     = 400000;
    localparam int SETTLE_CYCLES    = 2 * (1 + (QUEUE_DEPTH + 1) * MAX_RESULTS);
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASES           = 5;
    localparam int PHASE_ITEMS      = 28;

    logic clk;
    logic rst_n;
    bit   no_gaps;
    bit   rx_hold_req;
    int   items_sent;
    int   hold_writes;
    int   errors;
    int   outstanding;
    int   checked;

    etdq_item_if   item ();
    etdq_result_if result ();
    etdq_cfg_if    cfg ();

    extended_timer_deadline_queue_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    etdq_scoreboard checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .result      (result),
        .cfg         (cfg),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin : sink_side
        int stall;
        bit held;
        held = 1'b0;
        result.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (rx_hold_req && !held)
            begin
                held = 1'b1;
                result.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            stall = no_gaps ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid) @(posedge clk);
        end
    end

    function automatic logic [TIME_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(func_t fn, logic [TAG_W-1:0] tag,
                             logic [DELAY_W-1:0] dly, logic [TIME_W-1:0] dl);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid       <= 1'b1;
        item.func        <= fn;
        item.request_tag <= tag;
        item.delay       <= dly;
        item.deadline    <= dl;
        @(posedge clk);
        while (!item.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        item.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_hold(logic v);
        wait_idle();
        cfg.valid        <= 1'b1;
        cfg.hold_running <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        hold_writes++;
    endtask

    task automatic send_random_item();
        int               pick;
        int               form;
        logic [TAG_W-1:0] tag;
        pick = $urandom_range(0, 99);
        form = $urandom_range(0, 99);
        tag  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 7));
        if (pick < 35)
            send_item(FN_TICK, tag, $urandom, rand_word());
        else if (pick < 70)
        begin
            if (form < 55)
                send_item(FN_REQUEST, tag, 32'($urandom_range(1, 12)), rand_word());
            else if (form < 75)
                send_item(FN_REQUEST, tag, '0, 64'($urandom_range(0, 150)));
            else if (form < 88)
                send_item(FN_REQUEST, {5'd0, tag[2:0]}, '0, rand_word());
            else
                send_item(FN_REQUEST, {5'd0, tag[2:0]}, $urandom, rand_word());
        end
        else if (pick < 88)
            send_item(FN_CANCEL, tag, $urandom, rand_word());
        else
            send_item(FN_READ, tag, $urandom, rand_word());
    endtask

    initial
    begin : source_side
        logic [7:0] dup_tags [8];
        rst_n            <= 1'b0;
        item.valid       <= 1'b0;
        item.func        <= FN_TICK;
        item.request_tag <= '0;
        item.delay       <= '0;
        item.deadline    <= '0;
        cfg.valid        <= 1'b0;
        cfg.hold_running <= 1'b0;
        no_gaps          = 1'b0;
        rx_hold_req      = 1'b0;
        items_sent       = 0;
        hold_writes      = 0;
        dup_tags         = '{8'd3, 8'd7, 8'd3, 8'd7, 8'd200, 8'd201, 8'd128, 8'd64};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(FN_READ, 8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(FN_TICK, 8'h00, '0, '0);
        send_item(FN_REQUEST, 8'd1, '0, '0);
        send_item(FN_CANCEL, 8'd9, '0, '0);
        write_hold(1'b1);
        send_item(FN_READ, 8'd0, '0, '0);
        send_item(FN_TICK, 8'd0, '0, '0);
        send_item(FN_REQUEST, 8'hFF, 32'hFFFF_FFFF, '0);
        send_item(FN_REQUEST, 8'h00, '0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(FN_CANCEL, 8'hFF, '0, '0);
        send_item(FN_CANCEL, 8'h00, '0, '0);
        for (int i = 0; i < 8; i++)
        begin
            if (i % 2 == 0)
                send_item(FN_REQUEST, dup_tags[i], 32'd4, rand_word());
            else
                send_item(FN_REQUEST, dup_tags[i], '0, 64'd5);
        end
        send_item(FN_REQUEST, 8'd99, 32'd2, '0);
        send_item(FN_CANCEL, 8'd3, '0, '0);
        send_item(FN_REQUEST, 8'd30, 32'd5, '0);
        repeat (5) send_item(FN_TICK, 8'd0, '0, '0);
        write_hold(1'b0);
        send_item(FN_READ, 8'd0, '0, '0);
        send_item(FN_TICK, 8'd0, '0, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                write_hold(1'b1);
            else if (p == PHASES - 1)
                write_hold(1'b0);
            else
                write_hold(1'($urandom_range(0, 1)));
            no_gaps = (p == 2);
            if (p == 3)
                rx_hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_random_item();
        end
        no_gaps = 1'b0;
        wait_idle();

        $display("tb_top: %0d items, %0d results checked, %0d hold writes",
                 items_sent, checked, hold_writes);
        $display("tb_top: covered full queue, same-tick expiry, cancels, reads while %s",
                 "stopped and running, and a long output stall");
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
